### sv/qcom_pkg.sv
package qcom_pkg;

    localparam int unsigned COORD_BITS_DEF = 12;
    localparam int unsigned IDX_BITS = 2;
    localparam int unsigned NUM_PTS = 4;

    typedef logic [IDX_BITS-1:0] t_idx;

    typedef struct packed {
        t_idx tl;
        t_idx tr;
        t_idx bl;
        t_idx br;
    } t_order;

endpackage

### sv/qcom_sort.sv
module qcom_sort #(
    parameter int unsigned COORD_BITS = qcom_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_x [qcom_pkg::NUM_PTS],
    input  logic [COORD_BITS-1:0] i_y [qcom_pkg::NUM_PTS],
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_tl_x,
    output logic [COORD_BITS-1:0] o_tl_y,
    output logic [COORD_BITS-1:0] o_tr_x,
    output logic [COORD_BITS-1:0] o_tr_y,
    output logic [COORD_BITS-1:0] o_bl_x,
    output logic [COORD_BITS-1:0] o_bl_y,
    output logic [COORD_BITS-1:0] o_br_x,
    output logic [COORD_BITS-1:0] o_br_y,
    output qcom_pkg::t_order      o_order
);

    logic [COORD_BITS-1:0] r_x [qcom_pkg::NUM_PTS];
    logic [COORD_BITS-1:0] r_y [qcom_pkg::NUM_PTS];
    qcom_pkg::t_idx        r_i [qcom_pkg::NUM_PTS];
    logic                  r_valid;

    logic [COORD_BITS-1:0] n_x [qcom_pkg::NUM_PTS];
    logic [COORD_BITS-1:0] n_y [qcom_pkg::NUM_PTS];
    qcom_pkg::t_idx        n_i [qcom_pkg::NUM_PTS];

    // rank by count of points that come before: larger y, or equal y and lower index
    always_comb begin
        logic [1:0] rank;
        for (int k = 0; k < qcom_pkg::NUM_PTS; k++) begin
            n_x[k] = '0;
            n_y[k] = '0;
            n_i[k] = '0;
        end
        for (int a = 0; a < qcom_pkg::NUM_PTS; a++) begin
            rank = '0;
            for (int b = 0; b < qcom_pkg::NUM_PTS; b++) begin
                if (b < a && i_y[b] >= i_y[a]) rank = rank + 2'd1;
                if (b > a && i_y[b] > i_y[a]) rank = rank + 2'd1;
            end
            n_x[rank] = i_x[a];
            n_y[rank] = i_y[a];
            n_i[rank] = qcom_pkg::t_idx'(a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_i <= n_i;
    end

    logic top_sw, bot_sw;
    assign top_sw = !(r_x[0] < r_x[1]);
    assign bot_sw = !(r_x[2] < r_x[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_valid;
        end
        o_tl_x     <= top_sw ? r_x[1] : r_x[0];
        o_tl_y     <= top_sw ? r_y[1] : r_y[0];
        o_tr_x     <= top_sw ? r_x[0] : r_x[1];
        o_tr_y     <= top_sw ? r_y[0] : r_y[1];
        o_bl_x     <= bot_sw ? r_x[3] : r_x[2];
        o_bl_y     <= bot_sw ? r_y[3] : r_y[2];
        o_br_x     <= bot_sw ? r_x[2] : r_x[3];
        o_br_y     <= bot_sw ? r_y[2] : r_y[3];
        o_order.tl <= top_sw ? r_i[1] : r_i[0];
        o_order.tr <= top_sw ? r_i[0] : r_i[1];
        o_order.bl <= bot_sw ? r_i[3] : r_i[2];
        o_order.br <= bot_sw ? r_i[2] : r_i[3];
    end

endmodule

### sv/qcom_isqrt.sv
module qcom_isqrt #(
    parameter int unsigned IN_BITS  = 34,
    parameter int unsigned TAG_BITS = 1
) (
    input  logic                    i_clk,
    input  logic [IN_BITS-1:0]      i_val,
    input  logic [TAG_BITS-1:0]     i_tag,
    output logic [IN_BITS/2-1:0]    o_root,
    output logic [TAG_BITS-1:0]     o_tag
);

    localparam int unsigned RB    = IN_BITS / 2;
    localparam int unsigned PER   = 4;
    localparam int unsigned NSTG  = (RB + PER - 1) / PER;

    logic [IN_BITS-1:0]  r_rem  [1:NSTG];
    logic [RB-1:0]       r_root [1:NSTG];
    logic [TAG_BITS-1:0] r_tag  [1:NSTG];

    // restoring square root, four result bits per stage
    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [IN_BITS-1:0]  s_rem;
        logic [RB-1:0]       s_root;
        logic [TAG_BITS-1:0] s_tag;
        logic [IN_BITS-1:0]  n_rem;
        logic [RB-1:0]       n_root;
        if (s == 0) begin : g_in
            assign s_rem  = i_val;
            assign s_root = '0;
            assign s_tag  = i_tag;
        end else begin : g_mid
            assign s_rem  = r_rem[s];
            assign s_root = r_root[s];
            assign s_tag  = r_tag[s];
        end
        always_comb begin
            logic [IN_BITS+1:0] trial;
            logic [IN_BITS+1:0] cand;
            n_rem  = s_rem;
            n_root = s_root;
            for (int k = 0; k < PER; k++) begin
                if (s * PER + k < RB) begin
                    cand  = ({2'b0, IN_BITS'(n_root)} << (RB - s * PER - k))
                          | ((IN_BITS + 2)'(1) << (2 * (RB - 1 - s * PER - k)));
                    trial = {2'b0, n_rem};
                    if (trial >= cand) begin
                        n_rem  = IN_BITS'(trial - cand);
                        n_root = n_root | (RB'(1) << (RB - 1 - s * PER - k));
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[s+1]  <= n_rem;
            r_root[s+1] <= n_root;
            r_tag[s+1]  <= s_tag;
        end
    end

    assign o_root = r_root[NSTG];
    assign o_tag  = r_tag[NSTG];

endmodule

### sv/quad_corner_order_and_measure_unit.sv
// Channel | Direction | Signals
// request | in        | i_start, o_busy, i_p0_x .. i_p3_y
// result  | out       | o_valid, o_*_index, o_width_q4, o_height_q4, o_area_q8, o_center_*
// A request is taken every cycle; o_busy is always low.
// Data pass the sort stages, the midpoint, square and square-sum stages, the square
// root pipeline (four root bits per stage), a root register and the area multiply.
// Reset clears valid bits outside the root pipeline; payload registers are not reset.
// The receiver cannot stall, so no back-pressure exists.
module quad_corner_order_and_measure_unit #(
    parameter int unsigned COORD_BITS = qcom_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [COORD_BITS-1:0]   i_p0_x,
    input  logic [COORD_BITS-1:0]   i_p0_y,
    input  logic [COORD_BITS-1:0]   i_p1_x,
    input  logic [COORD_BITS-1:0]   i_p1_y,
    input  logic [COORD_BITS-1:0]   i_p2_x,
    input  logic [COORD_BITS-1:0]   i_p2_y,
    input  logic [COORD_BITS-1:0]   i_p3_x,
    input  logic [COORD_BITS-1:0]   i_p3_y,
    output logic                    o_valid,
    output logic [1:0]              o_top_left_index,
    output logic [1:0]              o_top_right_index,
    output logic [1:0]              o_bottom_left_index,
    output logic [1:0]              o_bottom_right_index,
    output logic [COORD_BITS+4:0]   o_width_q4,
    output logic [COORD_BITS+4:0]   o_height_q4,
    output logic [2*COORD_BITS+8:0] o_area_q8,
    output logic [COORD_BITS-1:0]   o_center_x,
    output logic [COORD_BITS-1:0]   o_center_y
);

    localparam int unsigned CB     = COORD_BITS;
    localparam int unsigned D2B    = 2 * CB + 1;
    localparam int unsigned SQB    = 2 * CB + 10;
    localparam int unsigned RTB    = SQB / 2;
    localparam int unsigned DB     = CB + 5;
    localparam int unsigned AB     = 2 * CB + 9;
    localparam int unsigned TAGB   = 1 + 8 + 2 * CB;

    assign o_busy = 1'b0;

    logic [CB-1:0] in_x [qcom_pkg::NUM_PTS];
    logic [CB-1:0] in_y [qcom_pkg::NUM_PTS];
    assign in_x = '{i_p0_x, i_p1_x, i_p2_x, i_p3_x};
    assign in_y = '{i_p0_y, i_p1_y, i_p2_y, i_p3_y};

    logic             s2_valid;
    logic [CB-1:0]    tlx, tly, trx, tr_y, blx, bly, brx, bry;
    qcom_pkg::t_order s2_order;

    qcom_sort #(.COORD_BITS(CB)) u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_x     (in_x),
        .i_y     (in_y),
        .o_valid (s2_valid),
        .o_tl_x  (tlx),
        .o_tl_y  (tly),
        .o_tr_x  (trx),
        .o_tr_y  (tr_y),
        .o_bl_x  (blx),
        .o_bl_y  (bly),
        .o_br_x  (brx),
        .o_br_y  (bry),
        .o_order (s2_order)
    );

    function automatic logic [CB-1:0] mid(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CB:1];
    endfunction

    function automatic logic [CB-1:0] adiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    logic             r3_valid;
    logic [CB-1:0]    r_wdx, r_wdy, r_hdx, r_hdy, r_cx, r_cy;
    qcom_pkg::t_order r3_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= s2_valid;
        end
        r_wdx    <= adiff(mid(blx, tlx), mid(trx, brx));
        r_wdy    <= adiff(mid(bly, tly), mid(tr_y, bry));
        r_hdx    <= adiff(mid(tlx, trx), mid(brx, blx));
        r_hdy    <= adiff(mid(tly, tr_y), mid(bry, bly));
        r_cx     <= mid(mid(tlx, brx), mid(trx, blx));
        r_cy     <= mid(mid(tly, bry), mid(tr_y, bly));
        r3_order <= s2_order;
    end

    logic             r4_valid;
    logic [2*CB-1:0]  r_wxx, r_wyy, r_hxx, r_hyy;
    logic [CB-1:0]    r4_cx, r4_cy;
    qcom_pkg::t_order r4_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r_wxx    <= r_wdx * r_wdx;
        r_wyy    <= r_wdy * r_wdy;
        r_hxx    <= r_hdx * r_hdx;
        r_hyy    <= r_hdy * r_hdy;
        r4_cx    <= r_cx;
        r4_cy    <= r_cy;
        r4_order <= r3_order;
    end

    logic             r5_valid;
    logic [D2B-1:0]   r_wd2, r_hd2;
    logic [CB-1:0]    r5_cx, r5_cy;
    qcom_pkg::t_order r5_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r_wd2    <= D2B'(r_wxx) + D2B'(r_wyy);
        r_hd2    <= D2B'(r_hxx) + D2B'(r_hyy);
        r5_cx    <= r4_cx;
        r5_cy    <= r4_cy;
        r5_order <= r4_order;
    end

    logic [TAGB-1:0] tag_in, tag_out, tag_unused;
    logic [RTB-1:0]  w_root, h_root;
    logic [SQB-1:0]  w_sq, h_sq;

    assign tag_in = {r5_valid, r5_order, r5_cx, r5_cy};
    assign w_sq   = {1'b0, r_wd2, 8'd0};
    assign h_sq   = {1'b0, r_hd2, 8'd0};

    qcom_isqrt #(.IN_BITS(SQB), .TAG_BITS(TAGB)) u_wroot (
        .i_clk  (i_clk),
        .i_val  (w_sq),
        .i_tag  (tag_in),
        .o_root (w_root),
        .o_tag  (tag_out)
    );

    qcom_isqrt #(.IN_BITS(SQB), .TAG_BITS(TAGB)) u_hroot (
        .i_clk  (i_clk),
        .i_val  (h_sq),
        .i_tag  (tag_in),
        .o_root (h_root),
        .o_tag  (tag_unused)
    );

    // tag valid bit rides the root pipeline unreset; gate it with a reset-cleared shadow
    localparam int unsigned RSTG = (RTB + 3) / 4;
    logic [RSTG-1:0] r_vpipe;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
        end else begin
            r_vpipe <= RSTG'({r_vpipe, r5_valid});
        end
    end

    logic             r7_valid;
    logic [DB-1:0]    r7_w, r7_h;
    logic [CB-1:0]    r7_cx, r7_cy;
    qcom_pkg::t_order r7_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= r_vpipe[RSTG-1] & tag_out[TAGB-1] & (tag_unused == tag_out);
        end
        r7_w     <= DB'(w_root);
        r7_h     <= DB'(h_root);
        r7_order <= tag_out[TAGB-2 -: 8];
        r7_cx    <= tag_out[2*CB-1:CB];
        r7_cy    <= tag_out[CB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r7_valid;
        end
        o_width_q4           <= r7_w;
        o_height_q4          <= r7_h;
        o_area_q8            <= AB'(r7_w * r7_h);
        o_center_x           <= r7_cx;
        o_center_y           <= r7_cy;
        o_top_left_index     <= r7_order.tl;
        o_top_right_index    <= r7_order.tr;
        o_bottom_left_index  <= r7_order.bl;
        o_bottom_right_index <= r7_order.br;
    end

    a_busy_low: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_idx_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_top_left_index != o_top_right_index)
                 && (o_bottom_left_index != o_bottom_right_index)
                 && (o_top_left_index != o_bottom_left_index)
                 && (o_top_left_index != o_bottom_right_index)
                 && (o_top_right_index != o_bottom_left_index)
                 && (o_top_right_index != o_bottom_right_index))
        else $error("corner indices not a permutation");
    a_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_width_q4 == '0 || o_height_q4 == '0) |-> o_area_q8 == '0)
        else $error("area nonzero with zero side");

endmodule

### dv/quad_corner_order_and_measure_unit_tb.sv
module quad_corner_order_and_measure_unit_tb;

    localparam int CB = 12;
    localparam int DB = CB + 5;
    localparam int AB = 2 * CB + 9;
    localparam int RAND_ITEMS = 930;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef logic [0:7][CB-1:0] t_quad;

    typedef struct packed {
        qcom_pkg::t_order order;
        logic [DB-1:0] width_q4;
        logic [DB-1:0] height_q4;
        logic [AB-1:0] area_q8;
        logic [CB-1:0] center_x;
        logic [CB-1:0] center_y;
    } t_quad_meas;

    typedef struct {
        t_quad      pts;
        bit         typed;
        t_quad_meas meas;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_start = 1'b0;
    logic          o_busy;
    logic [CB-1:0] i_p0_x = '0, i_p0_y = '0, i_p1_x = '0, i_p1_y = '0;
    logic [CB-1:0] i_p2_x = '0, i_p2_y = '0, i_p3_x = '0, i_p3_y = '0;
    logic          o_valid;
    logic [1:0]    o_top_left_index, o_top_right_index;
    logic [1:0]    o_bottom_left_index, o_bottom_right_index;
    logic [DB-1:0] o_width_q4, o_height_q4;
    logic [AB-1:0] o_area_q8;
    logic [CB-1:0] o_center_x, o_center_y;

    t_quad_meas pending_meas[$];
    t_row       corner_rows[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    bit         stim_done = 1'b0;

    quad_corner_order_and_measure_unit #(.COORD_BITS(CB)) dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] mid_dist(input logic [63:0] ax, ay, bx, by);
        logic [63:0] dx;
        logic [63:0] dy;
        dx = (ax >= bx) ? ax - bx : bx - ax;
        dy = (ay >= by) ? ay - by : by - ay;
        return int_root((dx * dx + dy * dy) << 8);
    endfunction

    function automatic t_quad_meas measure_quad(input t_quad q);
        logic [63:0] px[4], py[4];
        logic [1:0]  pi[4];
        logic [63:0] kx, ky;
        logic [1:0]  ki;
        int          j;
        int          tl, tr, bl, br;
        logic [63:0] mlx, mly, mtx, mty, mrx, mry, mbx, mby;
        logic [63:0] c1x, c1y, c2x, c2y, w, h;
        t_quad_meas  m;
        for (int i = 0; i < 4; i++) begin
            px[i] = q[2*i];
            py[i] = q[2*i+1];
            pi[i] = i[1:0];
        end
        for (int i = 1; i < 4; i++) begin
            kx = px[i]; ky = py[i]; ki = pi[i];
            j = i - 1;
            while (j >= 0 && py[j] < ky) begin
                px[j+1] = px[j]; py[j+1] = py[j]; pi[j+1] = pi[j];
                j--;
            end
            px[j+1] = kx; py[j+1] = ky; pi[j+1] = ki;
        end
        if (px[0] < px[1]) begin tl = 0; tr = 1; end else begin tl = 1; tr = 0; end
        if (px[2] < px[3]) begin bl = 2; br = 3; end else begin bl = 3; br = 2; end
        mlx = (px[bl] + px[tl]) >> 1; mly = (py[bl] + py[tl]) >> 1;
        mtx = (px[tl] + px[tr]) >> 1; mty = (py[tl] + py[tr]) >> 1;
        mrx = (px[tr] + px[br]) >> 1; mry = (py[tr] + py[br]) >> 1;
        mbx = (px[br] + px[bl]) >> 1; mby = (py[br] + py[bl]) >> 1;
        w = mid_dist(mlx, mly, mrx, mry) & ((64'd1 << DB) - 1);
        h = mid_dist(mtx, mty, mbx, mby) & ((64'd1 << DB) - 1);
        c1x = (px[tl] + px[br]) >> 1; c1y = (py[tl] + py[br]) >> 1;
        c2x = (px[tr] + px[bl]) >> 1; c2y = (py[tr] + py[bl]) >> 1;
        m.order.tl = pi[tl];
        m.order.tr = pi[tr];
        m.order.bl = pi[bl];
        m.order.br = pi[br];
        m.width_q4 = w[DB-1:0];
        m.height_q4 = h[DB-1:0];
        m.area_q8 = AB'(w * h);
        m.center_x = CB'((c1x + c2x) >> 1);
        m.center_y = CB'((c1y + c2y) >> 1);
        return m;
    endfunction

    task automatic add_row(input t_quad q, input bit typed, input t_quad_meas m);
        t_row r;
        r.pts = q;
        r.typed = typed;
        r.meas = m;
        corner_rows.push_back(r);
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // hold the request until it is taken, then log its expected measurement
    task automatic send_quad(input t_quad q, input bit typed, input t_quad_meas m);
        {i_p0_x, i_p0_y, i_p1_x, i_p1_y, i_p2_x, i_p2_y, i_p3_x, i_p3_y} <= q;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_meas.push_back(typed ? m : measure_quad(q));
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (pending_meas.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_quad random_quad;
        t_quad q;
        logic [CB-1:0] ya, yb;
        ya = CB'($urandom);
        yb = CB'($urandom);
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 3))
                0: q[i] = CB'($urandom);
                1: q[i] = (i % 2) ? ($urandom_range(0, 1) ? ya : yb) : CB'($urandom);
                2: q[i] = CB'($urandom_range(0, 7));
                default: q[i] = $urandom_range(0, 1) ? CB'(4095) : CB'($urandom_range(0, 3));
            endcase
        end
        return q;
    endfunction

    initial begin
        t_quad_meas m0;
        int burst;
        int n;
        m0 = '0;
        m0.order = '{tl: 2'd1, tr: 2'd0, bl: 2'd3, br: 2'd2};
        add_row('{default: '0}, 1'b1, m0);
        m0.center_x = 12'd4095;
        m0.center_y = 12'd4095;
        add_row('{default: 12'd4095}, 1'b1, m0);
        add_row('{12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095},
                1'b0, m0);
        add_row('{12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0},
                1'b0, m0);
        add_row('{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095},
                1'b0, m0);
        add_row('{12'd10, 12'd50, 12'd20, 12'd50, 12'd30, 12'd50, 12'd40, 12'd50},
                1'b0, m0);
        add_row('{12'd7, 12'd9, 12'd7, 12'd3, 12'd7, 12'd9, 12'd7, 12'd3},
                1'b0, m0);
        add_row('{12'd1, 12'd1, 12'd2, 12'd2, 12'd3, 12'd3, 12'd4, 12'd4},
                1'b0, m0);
        add_row('{12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
                1'b0, m0);
        add_row('{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095},
                1'b0, m0);
        add_row('{12'd2048, 12'd1000, 12'd100, 12'd2048, 12'd3900, 12'd2048, 12'd2048,
                  12'd3000}, 1'b0, m0);
        add_row('{12'd5, 12'd4095, 12'd4090, 12'd4000, 12'd3, 12'd2, 12'd4095, 12'd1},
                1'b0, m0);
        add_row('{12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hFFF, 12'h000, 12'h000, 12'hFFF},
                1'b0, m0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_rows[k]) send_quad(corner_rows[k].pts, corner_rows[k].typed,
                                          corner_rows[k].meas);
        drain();

        n = 0;
        while (n < RAND_ITEMS) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < RAND_ITEMS; b++) begin
                send_quad(random_quad(), 1'b0, m0);
                n++;
            end
            if (n >= RAND_ITEMS / 2 && n - burst < RAND_ITEMS / 2) begin
                drain();
            end else if ($urandom_range(0, 2) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        stim_done = 1'b1;
    end

    always @(posedge i_clk) begin
        t_quad_meas w;
        if (i_rst_n && o_valid) begin
            if (pending_meas.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                w = pending_meas.pop_front();
                if (o_top_left_index !== w.order.tl)
                    report("top_left_index", o_top_left_index, w.order.tl);
                if (o_top_right_index !== w.order.tr)
                    report("top_right_index", o_top_right_index, w.order.tr);
                if (o_bottom_left_index !== w.order.bl)
                    report("bottom_left_index", o_bottom_left_index, w.order.bl);
                if (o_bottom_right_index !== w.order.br)
                    report("bottom_right_index", o_bottom_right_index, w.order.br);
                if (o_width_q4 !== w.width_q4) report("width_q4", o_width_q4, w.width_q4);
                if (o_height_q4 !== w.height_q4) report("height_q4", o_height_q4, w.height_q4);
                if (o_area_q8 !== w.area_q8) report("area_q8", o_area_q8, w.area_q8);
                if (o_center_x !== w.center_x) report("center_x", o_center_x, w.center_x);
                if (o_center_y !== w.center_y) report("center_y", o_center_y, w.center_y);
            end
        end
        if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (stim_done) begin
            if (pending_meas.size() != 0) report("results missing", pending_meas.size(), 0);
            if (mismatches == 0) begin
                $display("quad_corner_order_and_measure_unit verification clean");
            end else begin
                $display("quad_corner_order_and_measure_unit verification failed");
            end
            $finish;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("quad_corner_order_and_measure_unit verification failed");
            $finish;
        end
    end
endmodule
